/* hw/rtl/wscs_pkg.sv */
// Shared types and constants for the wall segment collision scan block.
package wscs_pkg;

  localparam int COORD_BITS = 24;
  localparam int NUM_PROBES = 4;
  // probe coordinates: coordinate plus unsigned 16-bit offset minus 17-bit span
  localparam int PROBE_W    = ((COORD_BITS > 17) ? COORD_BITS : 17) + 2;
  localparam int DIFF_W     = PROBE_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_WALL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_SPAN   = 2'd2;

  localparam logic [6:0]  WALL_COUNT_RESET = 7'd0;
  localparam logic [15:0] PADDING          = 16'd256;
  localparam logic [16:0] PADDING2         = 17'd512;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic [5:0]                   wall_index;
    logic                         use_hint;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
  } item_beat_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] hit_wall;
  } result_beat_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic hint_rd;
    logic scan_rd;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_empty;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

endpackage

/* hw/rtl/wscs_ctrl.sv */
// Sequencer for loads and query scans of the wall table.
module wscs_ctrl
  import wscs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_mode,
  input  logic    item_use_hint,
  input  dp_sts_t sts,
  output logic    item_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    item_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (item_mode == MODE_LOAD) begin
            cmd.load   = 1'b1;
            state_next = ST_FINISH;
          end else begin
            cmd.hint_rd = item_use_hint;
            state_next  = sts.scan_empty ? ST_DRAIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/wscs_datapath.sv */
// Wall table, probe set-up, read/multiply/compare pipeline and result register.
module wscs_datapath
  import wscs_pkg::*;
#(
  parameter int MAX_WALLS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  item_beat_t            item,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  result_ready,
  output logic                  result_valid,
  output result_beat_t          result
);

  localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam int WW = 4 * COORD_BITS;

  localparam logic [1:0] ORI_ZERO = 2'd0;
  localparam logic [1:0] ORI_POS  = 2'd1;
  localparam logic [1:0] ORI_NEG  = 2'd2;

  typedef struct packed {
    logic signed [PROD_W-1:0] ab;
    logic signed [PROD_W-1:0] cd;
  } prod_pair_t;

  function automatic prod_pair_t orient_prods(
    input logic signed [PROBE_W-1:0] px, input logic signed [PROBE_W-1:0] py,
    input logic signed [PROBE_W-1:0] qx, input logic signed [PROBE_W-1:0] qy,
    input logic signed [PROBE_W-1:0] rx, input logic signed [PROBE_W-1:0] ry
  );
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] ex;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] ey;
    prod_pair_t               r;
    dy   = DIFF_W'(qy) - DIFF_W'(py);
    ex   = DIFF_W'(rx) - DIFF_W'(qx);
    dx   = DIFF_W'(qx) - DIFF_W'(px);
    ey   = DIFF_W'(ry) - DIFF_W'(qy);
    r.ab = dy * ex;
    r.cd = dx * ey;
    return r;
  endfunction

  function automatic logic [1:0] orient_code(input prod_pair_t pp);
    logic [1:0] c;
    if (pp.ab > pp.cd) begin
      c = ORI_POS;
    end else if (pp.ab < pp.cd) begin
      c = ORI_NEG;
    end else begin
      c = ORI_ZERO;
    end
    return c;
  endfunction

  // configuration
  logic [6:0]  wall_count;
  logic [15:0] pad_offset;
  logic [16:0] pad_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_count <= WALL_COUNT_RESET;
      pad_offset <= PADDING;
      pad_span   <= PADDING2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WALL_COUNT: wall_count <= cfg_data[6:0];
        CFG_PAD_OFFSET: pad_offset <= cfg_data[15:0];
        CFG_PAD_SPAN:   pad_span   <= cfg_data;
        default:        ;
      endcase
    end
  end

  logic [CW-1:0] n_eff;
  logic [CW-1:0] cnt;
  logic          idx_ok;

  assign n_eff  = (32'(wall_count) > MAX_WALLS) ? CW'(MAX_WALLS) : CW'(wall_count);
  assign idx_ok = 32'(item.wall_index) < MAX_WALLS;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.accept) begin
      cnt <= '0;
    end else if (cmd.scan_rd) begin
      cnt <= cnt + CW'(1);
    end
  end

  // wall table
  logic [WW-1:0] wall_mem [MAX_WALLS];
  logic [WW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  assign rd_addr = cmd.hint_rd ? AW'(item.wall_index) : cnt[AW-1:0];
  assign rd_en   = (cmd.hint_rd && idx_ok) || cmd.scan_rd;

  always_ff @(posedge clk) begin
    if (cmd.load && idx_ok) begin
      wall_mem[AW'(item.wall_index)] <= {item.ax, item.ay, item.bx, item.by};
    end
    if (rd_en) begin
      rd_data <= wall_mem[rd_addr];
    end
  end

  // query set-up
  logic signed [PROBE_W-1:0] q_x, q_y, q_xo, q_xs, q_yo, q_ys;
  logic                      q_hint;
  logic signed [PROBE_W-1:0] off_s, spn_s, in_x, in_y;

  assign off_s = PROBE_W'($signed({1'b0, pad_offset}));
  assign spn_s = PROBE_W'($signed({1'b0, pad_span}));
  assign in_x  = PROBE_W'(item.ax);
  assign in_y  = PROBE_W'(item.ay);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_x    <= in_x;
      q_y    <= in_y;
      q_xo   <= in_x + off_s;
      q_xs   <= in_x + off_s - spn_s;
      q_yo   <= in_y + off_s;
      q_ys   <= in_y + off_s - spn_s;
      q_hint <= item.use_hint;
    end
  end

  logic signed [PROBE_W-1:0] pr_px [NUM_PROBES];
  logic signed [PROBE_W-1:0] pr_qy [NUM_PROBES];

  assign pr_px[0] = q_xo;
  assign pr_px[1] = q_xo;
  assign pr_px[2] = q_xs;
  assign pr_px[3] = q_xs;
  assign pr_qy[0] = q_yo;
  assign pr_qy[1] = q_ys;
  assign pr_qy[2] = q_ys;
  assign pr_qy[3] = q_yo;

  // read stage tag
  logic          r_valid;
  logic          r_hint;
  logic [AW-1:0] r_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= rd_en;
    end
    r_hint <= cmd.hint_rd;
    r_idx  <= rd_addr;
  end

  // multiply stage
  logic signed [PROBE_W-1:0] w_sx, w_sy, w_ex, w_ey;
  prod_pair_t                pa   [NUM_PROBES][4];
  prod_pair_t                prod [NUM_PROBES][4];
  logic                      p_valid;
  logic                      p_hint;
  logic [AW-1:0]             p_idx;

  assign w_sx = PROBE_W'($signed(rd_data[4*COORD_BITS-1 -: COORD_BITS]));
  assign w_sy = PROBE_W'($signed(rd_data[3*COORD_BITS-1 -: COORD_BITS]));
  assign w_ex = PROBE_W'($signed(rd_data[2*COORD_BITS-1 -: COORD_BITS]));
  assign w_ey = PROBE_W'($signed(rd_data[COORD_BITS-1 -: COORD_BITS]));

  always_comb begin
    for (int k = 0; k < NUM_PROBES; k++) begin
      pa[k][0] = orient_prods(pr_px[k], q_y, q_x, pr_qy[k], w_sx, w_sy);
      pa[k][1] = orient_prods(pr_px[k], q_y, q_x, pr_qy[k], w_ex, w_ey);
      pa[k][2] = orient_prods(w_sx, w_sy, w_ex, w_ey, pr_px[k], q_y);
      pa[k][3] = orient_prods(w_sx, w_sy, w_ex, w_ey, q_x, pr_qy[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= r_valid;
    end
    p_hint <= r_hint;
    p_idx  <= r_idx;
    if (r_valid) begin
      prod <= pa;
    end
  end

  // compare stage and first-hit record
  logic [NUM_PROBES-1:0] crossed;
  logic [NUM_PROBES-1:0] allow;
  logic [NUM_PROBES-1:0] found;
  logic [AW-1:0]         found_idx [NUM_PROBES];

  always_comb begin
    for (int k = 0; k < NUM_PROBES; k++) begin
      crossed[k] = (orient_code(prod[k][0]) != orient_code(prod[k][1]))
                && (orient_code(prod[k][2]) != orient_code(prod[k][3]));
      allow[k]   = (k == 0) ? (p_hint || !q_hint) : !p_hint;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      found <= '0;
    end else if (p_valid) begin
      for (int k = 0; k < NUM_PROBES; k++) begin
        if (allow[k] && crossed[k] && !found[k]) begin
          found[k]     <= 1'b1;
          found_idx[k] <= p_idx;
        end
      end
    end
  end

  // result register
  result_beat_t res_next;

  always_comb begin
    res_next = '0;
    priority if (found[0]) begin
      res_next = '{hit: 1'b1, hit_wall: 6'(found_idx[0])};
    end else if (found[1]) begin
      res_next = '{hit: 1'b1, hit_wall: 6'(found_idx[1])};
    end else if (found[2]) begin
      res_next = '{hit: 1'b1, hit_wall: 6'(found_idx[2])};
    end else if (found[3]) begin
      res_next = '{hit: 1'b1, hit_wall: 6'(found_idx[3])};
    end else begin
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  assign sts.scan_empty = (n_eff == '0);
  assign sts.scan_last  = (cnt == n_eff - CW'(1));
  assign sts.pipe_busy  = r_valid || p_valid;
  assign sts.out_free   = !result_valid || result_ready;

endmodule

/* hw/rtl/wall_segment_collision_scan_top.sv */
// Top level of the wall segment collision scan block.
// A load beat writes one wall into the table and its result beat (hit 0) is written once
// the output register is free. A query beat scans n walls, n being wall_count saturated to
// MAX_WALLS: the wall table has one read port, so the scan reads one wall per cycle and
// tests the probes against it in parallel in a three-stage read, multiply and compare
// pipeline, probe 0 only when no hint is given; a hinted first probe adds its own read
// in the acceptance cycle. One item is worked on at a time; a finished result waits in the
// output register while the next item is accepted. The table is not cleared at reset.
module wall_segment_collision_scan_top
  import wscs_pkg::*;
#(
  parameter int MAX_WALLS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_beat_t            item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_beat_t          result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  wscs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_mode     (item.mode),
    .item_use_hint (item.use_hint),
    .sts           (sts),
    .item_ready    (item_ready),
    .cmd           (cmd)
  );

  wscs_datapath #(
    .MAX_WALLS (MAX_WALLS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result written while output register still held a beat");

  a_ready_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !sts.pipe_busy)
    else $error("new item offered while scan pipeline still busy");

  a_load_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && (item.mode == MODE_LOAD)) |=> !item_ready)
    else $error("item accepted in the cycle after a load");

  a_miss_zero_index: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit) |-> (result.hit_wall == 6'd0))
    else $error("miss reported with non-zero wall index");
`endif

endmodule

/* dv/tb_wall_segment_collision_scan_top.sv */
// Self-checking testbench for the wall segment collision scan block: directed and random beats.
module tb_wall_segment_collision_scan_top;
  import wscs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WALLS = 64;
  localparam int IDLE_PCT = 22;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int SCENE = 16384;
  localparam int ITEMS_PER_SETTING = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef enum logic [1:0] {ORI_FLAT, ORI_POS, ORI_NEG} orient_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_beat_t            item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_beat_t          result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wall_segment_collision_scan_top #(.MAX_WALLS(MAX_WALLS)) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // own copy of the wall table and registers
  longint wall_sx[MAX_WALLS];
  longint wall_sy[MAX_WALLS];
  longint wall_ex[MAX_WALLS];
  longint wall_ey[MAX_WALLS];
  logic [6:0]  cur_wall_count = WALL_COUNT_RESET;
  logic [15:0] cur_pad_offset = PADDING;
  logic [16:0] cur_pad_span   = PADDING2;

  result_beat_t expected_hits[$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  bit           steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic orient_e orientation(longint px, longint py, longint qx, longint qy,
                                          longint rx, longint ry);
    longint v;
    v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (v == 0) return ORI_FLAT;
    return (v > 0) ? ORI_POS : ORI_NEG;
  endfunction

  function automatic bit crosses(longint p1x, longint p1y, longint q1x, longint q1y, int w);
    return orientation(p1x, p1y, q1x, q1y, wall_sx[w], wall_sy[w]) !=
           orientation(p1x, p1y, q1x, q1y, wall_ex[w], wall_ey[w]) &&
           orientation(wall_sx[w], wall_sy[w], wall_ex[w], wall_ey[w], p1x, p1y) !=
           orientation(wall_sx[w], wall_sy[w], wall_ex[w], wall_ey[w], q1x, q1y);
  endfunction

  // applies a load to the table, or scans the probes for a query
  function automatic result_beat_t wall_scan_predict(item_beat_t it);
    result_beat_t r;
    longint x, y, o, s;
    longint ox[NUM_PROBES], oy[NUM_PROBES], tx[NUM_PROBES], ty[NUM_PROBES];
    int n;
    r = '0;
    x = longint'($signed(it.ax));
    y = longint'($signed(it.ay));
    if (it.mode == MODE_LOAD) begin
      wall_sx[it.wall_index] = x;
      wall_sy[it.wall_index] = y;
      wall_ex[it.wall_index] = longint'($signed(it.bx));
      wall_ey[it.wall_index] = longint'($signed(it.by));
      return r;
    end
    o = longint'(cur_pad_offset);
    s = longint'(cur_pad_span);
    n = (cur_wall_count > MAX_WALLS) ? MAX_WALLS : int'(cur_wall_count);
    ox[0] = x + o;     oy[0] = y; tx[0] = x; ty[0] = y + o;
    ox[1] = x + o;     oy[1] = y; tx[1] = x; ty[1] = y + o - s;
    ox[2] = x + o - s; oy[2] = y; tx[2] = x; ty[2] = y + o - s;
    ox[3] = x + o - s; oy[3] = y; tx[3] = x; ty[3] = y + o;
    for (int k = 0; k < NUM_PROBES; k++) begin
      if (k == 0 && it.use_hint) begin
        if (crosses(ox[0], oy[0], tx[0], ty[0], int'(it.wall_index))) begin
          r.hit = 1'b1;
          r.hit_wall = it.wall_index;
          return r;
        end
      end else begin
        for (int i = 0; i < n; i++) begin
          if (crosses(ox[k], oy[k], tx[k], ty[k], i)) begin
            r.hit = 1'b1;
            r.hit_wall = 6'(i);
            return r;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(input item_beat_t it);
    while (!steady && $urandom_range(99) < IDLE_PCT) @(negedge clk);
    item_valid = 1'b1;
    item = it;
    do @(posedge clk); while (!item_ready);
    expected_hits.push_back(wall_scan_predict(it));
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    while (expected_hits.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WALL_COUNT: cur_wall_count = data[6:0];
      CFG_PAD_OFFSET: cur_pad_offset = data[15:0];
      CFG_PAD_SPAN:   cur_pad_span = data[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input int wc, input int o, input int s);
    cfg_write(CFG_WALL_COUNT, CFG_DATA_W'(wc));
    cfg_write(CFG_PAD_OFFSET, CFG_DATA_W'(o));
    cfg_write(CFG_PAD_SPAN, CFG_DATA_W'(s));
  endtask

  function automatic item_beat_t load_beat(int slot, longint sx, longint sy,
                                          longint ex, longint ey);
    item_beat_t it;
    it = '0;
    it.mode = MODE_LOAD;
    it.wall_index = 6'(slot);
    it.use_hint = 1'($urandom_range(1));
    it.ax = sx[COORD_BITS-1:0];
    it.ay = sy[COORD_BITS-1:0];
    it.bx = ex[COORD_BITS-1:0];
    it.by = ey[COORD_BITS-1:0];
    return it;
  endfunction

  function automatic item_beat_t query_beat(longint x, longint y, bit hint, int idx);
    item_beat_t it;
    it = '0;
    it.mode = MODE_QUERY;
    it.wall_index = 6'(idx);
    it.use_hint = hint;
    it.ax = x[COORD_BITS-1:0];
    it.ay = y[COORD_BITS-1:0];
    it.bx = COORD_BITS'($urandom);
    it.by = COORD_BITS'($urandom);
    return it;
  endfunction

  function automatic longint rand_coord(bit full);
    logic signed [COORD_BITS-1:0] c;
    if (full) begin
      c = COORD_BITS'($urandom);
      return longint'(c);
    end
    return longint'($urandom_range(2 * SCENE)) - SCENE;
  endfunction

  function automatic item_beat_t rand_load(int slot);
    bit full;
    full = ($urandom_range(99) < 15);
    return load_beat(slot, rand_coord(full), rand_coord(full), rand_coord(full),
                     rand_coord(full));
  endfunction

  // puts the chosen probe's midpoint at the wall's midpoint plus a small random jitter
  function automatic item_beat_t aimed_query(int w, int probe);
    longint mx, my, dx, dy, o, s;
    int jit;
    o = longint'(cur_pad_offset);
    s = longint'(cur_pad_span);
    mx = (wall_sx[w] + wall_ex[w]) / 2;
    my = (wall_sy[w] + wall_ey[w]) / 2;
    dx = (probe < 2) ? o / 2 : (o - s) / 2;
    dy = (probe == 0 || probe == 3) ? o / 2 : (o - s) / 2;
    jit = $urandom_range(8);
    return query_beat(mx - dx + jit - 4, my - dy - jit + 4, 1'($urandom_range(1)),
                      ($urandom_range(1) != 0) ? w : int'($urandom_range(MAX_WALLS - 1)));
  endfunction

  task automatic check_result(input result_beat_t got);
    result_beat_t want;
    results_seen++;
    if (expected_hits.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: unexpected beat hit=%0b wall=%0d", results_seen, got.hit,
                 got.hit_wall);
      return;
    end
    want = expected_hits.pop_front();
    if (got.hit !== want.hit || got.hit_wall !== want.hit_wall) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected hit=%0b wall=%0d, got hit=%0b wall=%0d", results_seen,
                 want.hit, want.hit_wall, got.hit, got.hit_wall);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) check_result(result);
  end

  always @(negedge clk) begin
    result_ready = steady || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic test_empty_table();
    send_item(query_beat(0, 0, 1'b0, 0));
    send_item(query_beat(longint'(C_MAX), longint'(C_MIN), 1'b0, 63));
  endtask

  task automatic test_load_extremes();
    send_item(load_beat(63, longint'(C_MIN), longint'(C_MIN), longint'(C_MAX),
                        longint'(C_MAX)));
    send_item(load_beat(5, longint'(C_MIN), longint'(C_MAX), longint'(C_MAX),
                        longint'(C_MIN)));
  endtask

  task automatic test_probe_order();
    send_item(load_beat(0, 5000, 5000, 6000, 5000));
    send_item(load_beat(1, -1000, -1000, -100, -100));
    send_item(load_beat(2, 0, 0, 1000, 1000));
    send_item(load_beat(3, 512, -256, -256, 512));
    send_item(load_beat(4, 256, 0, 1000, 0));
    cfg_write(CFG_WALL_COUNT, CFG_DATA_W'(2));
    send_item(query_beat(0, 0, 1'b0, 0));
    cfg_write(CFG_WALL_COUNT, CFG_DATA_W'(5));
    send_item(query_beat(0, 0, 1'b0, 0));
    send_item(query_beat(-2000, 300, 1'b0, 0));
  endtask

  task automatic test_hint();
    send_item(query_beat(0, 0, 1'b1, 63));
    send_item(query_beat(0, 0, 1'b1, 0));
    send_item(query_beat(0, 0, 1'b1, 5));
  endtask

  task automatic test_touch_and_collinear();
    send_item(query_beat(0, 0, 1'b1, 4));
    send_item(query_beat(0, 0, 1'b1, 3));
    cfg_write(CFG_WALL_COUNT, CFG_DATA_W'(4));
    send_item(query_beat(128, 128, 1'b0, 0));
  endtask

  task automatic test_offset_extremes();
    apply_setting(6, 65535, 131071);
    send_item(query_beat(longint'(C_MAX), longint'(C_MAX), 1'b1, 63));
    send_item(query_beat(longint'(C_MIN), longint'(C_MIN), 1'b0, 0));
    apply_setting(6, 0, 0);
    send_item(query_beat(0, 0, 1'b1, 63));
    send_item(query_beat(-1, 0, 1'b0, 0));
    cfg_write(CFG_UNUSED, 17'h1ffff);
  endtask

  task automatic test_fill_table();
    apply_setting(0, int'(PADDING), int'(PADDING2));
    for (int i = 0; i < MAX_WALLS; i++) send_item(rand_load(i));
  endtask

  task automatic run_traffic(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 20)
        send_item(rand_load($urandom_range(MAX_WALLS - 1)));
      else if (pick < 65)
        send_item(aimed_query($urandom_range(MAX_WALLS - 1), $urandom_range(NUM_PROBES - 1)));
      else if (pick < 85)
        send_item(query_beat(rand_coord(1'b0), rand_coord(1'b0), 1'($urandom_range(1)),
                             $urandom_range(MAX_WALLS - 1)));
      else
        send_item(query_beat(rand_coord(1'b1), rand_coord(1'b1), 1'($urandom_range(1)),
                             $urandom_range(MAX_WALLS - 1)));
    end
  endtask

  // several register settings, the extremes and the saturated wall count among them
  task automatic test_random_traffic();
    apply_setting(64, int'(PADDING), int'(PADDING2));
    run_traffic(ITEMS_PER_SETTING);
    apply_setting(0, 0, 0);
    run_traffic(ITEMS_PER_SETTING);
    apply_setting(127, 65535, 131071);
    run_traffic(ITEMS_PER_SETTING);
    apply_setting(65, $urandom_range(65535), $urandom_range(131071));
    steady = 1'b1;
    run_traffic(ITEMS_PER_SETTING);
    steady = 1'b0;
    apply_setting(1, $urandom_range(65535), $urandom_range(131071));
    run_traffic(ITEMS_PER_SETTING);
    apply_setting(16, 1024, 0);
    run_traffic(ITEMS_PER_SETTING);
    apply_setting(40, 0, 131071);
    run_traffic(ITEMS_PER_SETTING);
    apply_setting(64, $urandom_range(65535), $urandom_range(131071));
    run_traffic(ITEMS_PER_SETTING);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_table();
    test_load_extremes();
    test_probe_order();
    test_hint();
    test_touch_and_collinear();
    test_offset_extremes();
    test_fill_table();
    test_random_traffic();
    while (expected_hits.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_hits.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
